FILE: src/mmsp_pkg.sv
package mmsp_pkg;

  // channel count and derived widths
  localparam int NUM_MOTORS = 4;
  localparam int MOT_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int OUT_N      = (NUM_MOTORS < 4) ? NUM_MOTORS : 4;

  // field widths
  localparam int MOTOR_W = 2;
  localparam int CMD_W   = 2;
  localparam int DATA_W  = 32;
  localparam int STEP_W  = 16;
  localparam int CNT_W   = $clog2(DATA_W);

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_QUEUE = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_TICK,
    ST_DIV,
    ST_DONE
  } state_e;

  // one channel entry in the channel memory
  typedef struct packed {
    logic [DATA_W-1:0] remaining;
    logic [DATA_W-1:0] position;
  } chan_t;

  typedef struct packed {
    logic             en;
    logic [MOT_W-1:0] addr;
    chan_t            data;
  } mem_wr_t;

endpackage

FILE: src/mmsp_chan_mem.sv
module mmsp_chan_mem
  import mmsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [MOT_W-1:0] rd_addr_i,
  input  mem_wr_t          wr_i,
  output chan_t            rd_data_o
);

  chan_t                 mem_q [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] vld_q;
  chan_t                 rd_data_q;
  logic                  rd_vld_q;

  // entry valid bits, an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // storage and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: src/mmsp_divider.sv
module mmsp_divider
  import mmsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [STEP_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  logic              run_q, done_q, zero_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] dvd_q, quo_q;
  logic [STEP_W-1:0] rem_q, dsr_q;
  logic [STEP_W:0]   shift_rem;
  logic [STEP_W:0]   diff;
  logic              fits;

  // one restoring step per cycle
  always_comb begin
    shift_rem = {rem_q, dvd_q[DATA_W-1]};
    fits      = shift_rem >= {1'b0, dsr_q};
    diff      = shift_rem - {1'b0, dsr_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DATA_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
      quo_q <= {quo_q[DATA_W-2:0], fits};
      rem_q <= fits ? diff[STEP_W-1:0] : shift_rem[STEP_W-1:0];
    end
  end

  // a zero divisor gives a zero quotient
  assign done_o     = done_q;
  assign quotient_o = zero_q ? '0 : quo_q;

endmodule

FILE: src/multi_motor_step_pulse_queue_top.sv
// Step pulse generator for NUM_MOTORS stepper channels. Each item carries a command: a tick
// toggles the step pulse of every busy channel (a falling edge takes one step and moves the
// position by step_size), queue loads a step count and direction, move loads the distance to
// the target divided by step_size, and query only reports. Every item returns one result with
// the pulse, direction and busy bits of motors 0 to 3 and the position of the addressed motor.
// Step counts and positions live in a channel memory with a registered read; flags are in
// flip-flops. One item is in work at a time: queue and query pass through the data and done
// states, a tick sweeps the channel memory one entry per cycle, and a move waits in the divide
// state for the 32-step iterative divider. A finished result waits in the output register
// while the next item is taken. step_size is to be written through the config port only
// while the block is idle, which the block does not enforce; the port is always ready.
module multi_motor_step_pulse_queue_top
  import mmsp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [STEP_W-1:0]        cfg_data_i,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [MOTOR_W-1:0]       motor_i,
  input  logic signed [DATA_W-1:0] target_position_i,
  input  logic [DATA_W-1:0]        step_count_i,
  input  logic                     forward_i,
  // results
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [3:0]               step_levels_o,
  output logic [3:0]               direction_bits_o,
  output logic [3:0]               busy_bits_o,
  output logic signed [DATA_W-1:0] motor_position_o
);

  localparam logic [MOT_W-1:0] LAST_IDX = MOT_W'(NUM_MOTORS - 1);

  state_e                state_q, state_d;
  cmd_e                  cmd_q;
  logic [MOTOR_W-1:0]    motor_q;
  logic                  motor_ok_q;
  logic [DATA_W-1:0]     target_q, count_q;
  logic                  fwd_q, mv_fwd_q, mv_fwd_d;
  logic [DATA_W-1:0]     pos_q, pos_d;
  logic [MOT_W-1:0]      idx_q;
  logic [NUM_MOTORS-1:0] pulse_q, pulse_d, dir_q, dir_d, busy_q, busy_d;
  logic [STEP_W-1:0]     step_size_q;
  logic                  out_valid_q;
  logic [3:0]            levels_q, dirs_q, busys_q;
  logic [DATA_W-1:0]     out_pos_q;

  logic                  in_acc, motor_ok, out_free, load_out;
  logic                  rd_en;
  logic [MOT_W-1:0]      rd_addr, maddr;
  mem_wr_t               wr;
  chan_t                 rd_data;
  logic                  div_start, div_done;
  logic [DATA_W-1:0]     div_quot, move_dist, new_rem, new_pos;
  logic                  mv_fwd;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign motor_ok    = (32'(motor_i) < NUM_MOTORS);
  assign maddr       = MOT_W'(motor_q);
  assign out_free    = !out_valid_q || !out_stall_i;

  mmsp_chan_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  mmsp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (move_dist),
    .divisor_i  (step_size_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_e'(cmd_i) == CMD_TICK) begin
            state_d = ST_TICK;
          end else if (motor_ok) begin
            state_d = ST_DATA;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DATA: state_d = (cmd_q == CMD_MOVE) ? ST_DIV : ST_DONE;
      ST_TICK: if (idx_q == LAST_IDX) state_d = ST_DONE;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory read, divider start and result load
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_en   = in_acc;
        rd_addr = (cmd_e'(cmd_i) == CMD_TICK) ? '0 : MOT_W'(motor_i);
      end
      ST_DATA: div_start = (cmd_q == CMD_MOVE);
      ST_TICK: begin
        rd_en   = (idx_q != LAST_IDX);
        rd_addr = idx_q + 1'b1;
      end
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // move distance toward the target
  always_comb begin
    mv_fwd    = $signed(target_q) > $signed(rd_data.position);
    move_dist = mv_fwd ? (target_q - rd_data.position) : (rd_data.position - target_q);
  end

  // channel update and memory write back
  always_comb begin
    pulse_d  = pulse_q;
    dir_d    = dir_q;
    busy_d   = busy_q;
    pos_d    = pos_q;
    mv_fwd_d = mv_fwd_q;
    wr       = '0;
    new_rem  = rd_data.remaining - 1'b1;
    new_pos  = dir_q[idx_q] ? (rd_data.position + DATA_W'(step_size_q))
                            : (rd_data.position - DATA_W'(step_size_q));
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pos_d = '0;
        end
      end
      ST_DATA: begin
        pos_d    = rd_data.position;
        mv_fwd_d = mv_fwd;
        if (cmd_q == CMD_QUEUE) begin
          wr.en          = 1'b1;
          wr.addr        = maddr;
          wr.data        = '{remaining: count_q, position: rd_data.position};
          pulse_d[maddr] = 1'b0;
          busy_d[maddr]  = (count_q != '0);
          if (count_q != '0) begin
            dir_d[maddr] = fwd_q;
          end
        end
      end
      ST_TICK: begin
        if (busy_q[idx_q]) begin
          if (pulse_q[idx_q]) begin
            pulse_d[idx_q] = 1'b0;
            busy_d[idx_q]  = (new_rem != '0);
            wr.en          = 1'b1;
            wr.addr        = idx_q;
            wr.data        = '{remaining: new_rem, position: new_pos};
          end else begin
            pulse_d[idx_q] = 1'b1;
          end
        end
        // capture the addressed channel's position after its step
        if (motor_ok_q && (idx_q == maddr)) begin
          pos_d = (busy_q[idx_q] && pulse_q[idx_q]) ? new_pos : rd_data.position;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          wr.en          = 1'b1;
          wr.addr        = maddr;
          wr.data        = '{remaining: div_quot, position: pos_q};
          pulse_d[maddr] = 1'b0;
          busy_d[maddr]  = (div_quot != '0);
          if (div_quot != '0) begin
            dir_d[maddr] = mv_fwd_q;
          end
        end
      end
      default: ;
    endcase
  end

  // control and flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pulse_q     <= '0;
      dir_q       <= '1;
      busy_q      <= '0;
      step_size_q <= STEP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pulse_q <= pulse_d;
      dir_q   <= dir_d;
      busy_q  <= busy_d;
      if (in_acc) begin
        idx_q <= '0;
      end else if (state_q == ST_TICK) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cfg_valid_i) begin
        step_size_q <= cfg_data_i;
      end
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    mv_fwd_q <= mv_fwd_d;
    if (in_acc) begin
      cmd_q      <= cmd_e'(cmd_i);
      motor_q    <= motor_i;
      motor_ok_q <= motor_ok;
      target_q   <= target_position_i;
      count_q    <= step_count_i;
      fwd_q      <= forward_i;
    end
    if (load_out) begin
      levels_q  <= 4'(pulse_q[OUT_N-1:0]);
      dirs_q    <= 4'(dir_q[OUT_N-1:0]);
      busys_q   <= 4'(busy_q[OUT_N-1:0]);
      out_pos_q <= pos_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_levels_o    = levels_q;
  assign direction_bits_o = dirs_q;
  assign busy_bits_o      = busys_q;
  assign motor_position_o = out_pos_q;

`ifndef NO_ASSERTIONS
  // the divider only finishes while a move waits for it
  a_div_done_in_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside a move");

  // a high pulse only on a channel with steps left
  a_pulse_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pulse_q & ~busy_q) == '0)
    else $error("step pulse high on an idle channel");

  // an accepted item always takes the block out of idle before the next transfer
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("item accepted without leaving idle");
`endif

endmodule
